### rtl/file_name_hash_defines.svh
// ----------------------------------------------------------------------------
// file_name_hash_defines
// Assertion macros shared by the file name hash block.
// ----------------------------------------------------------------------------
`ifndef FILE_NAME_HASH_DEFINES_SVH
`define FILE_NAME_HASH_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FNH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("file_name_hash: same-cycle check failed");

// next-cycle implication, checked out of reset
`define FNH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("file_name_hash: next-cycle check failed");

`endif

### rtl/fnh_pkg.sv
// ----------------------------------------------------------------------------
// fnh_pkg
// Types, constants and helper functions of the file name hash block.
// ----------------------------------------------------------------------------
package fnh_pkg;

    localparam int JOB_CNT_W  = 11;
    localparam int EXT_CODE_W = 3;
    localparam int EXT_COUNT  = 7;
    localparam int SUM_W      = 17;
    localparam int XOR_W      = 29;

    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] LOWER_BIT    = 8'h20;
    localparam logic [7:0] CASE_MASK    = 8'hDF;
    localparam logic [7:0] HASH_BIAS    = 8'h1A;

    localparam logic [23:0] EXT_TABLE [EXT_COUNT] = '{
        24'h64726D,
        24'h63726D,
        24'h74696D,
        24'h736D70,
        24'h736E64,
        24'h736D66,
        24'h736E66
    };

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in;

    typedef struct packed {
        logic [31:0] name_hash;
        logic        name_too_long;
    } t_out;

    typedef struct packed {
        logic                  hit;
        logic [EXT_CODE_W-1:0] code;
    } t_ext_hit;

    typedef struct packed {
        logic [JOB_CNT_W-1:0]  end_cnt;
        logic [EXT_CODE_W-1:0] code;
        logic                  no_dot;
        logic                  too_long;
    } t_job;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            r = c | LOWER_BIT;
        end
        return r;
    endfunction

    function automatic t_ext_hit ext_lookup(input logic [23:0] ext);
        t_ext_hit r;
        r = '0;
        for (int i = 0; i < EXT_COUNT; i++) begin
            if (!r.hit && ext == EXT_TABLE[i]) begin
                r.hit  = 1'b1;
                r.code = EXT_CODE_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] hash_value(input logic [7:0] c);
        logic [7:0] f;
        f = c;
        if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            f = c & CASE_MASK;
        end
        return f - HASH_BIAS;
    endfunction

endpackage

### rtl/fnh_ram.sv
// ----------------------------------------------------------------------------
// fnh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fnh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### rtl/fnh_front.sv
// ----------------------------------------------------------------------------
// fnh_front
// Stores each accepted character that fits, tracks the first dot and
// classifies the extension at the last character into a hash job.
// ----------------------------------------------------------------------------
module fnh_front #(
    parameter int MAX_LEN = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  fnh_pkg::t_in               i_in,
    output logic                       o_we,
    output logic [$clog2(MAX_LEN)-1:0] o_waddr,
    output logic [7:0]                 o_wdata,
    output logic                       o_push,
    output fnh_pkg::t_job              o_job
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]     r_dot_idx, n_dot_idx;
    logic              r_dot_seen, n_dot_seen;
    logic              r_ovf, n_ovf;
    logic [7:0]        r_c1, r_c0;

    logic              room;
    logic              first_dot;
    logic [CW-1:0]     cnt_i;
    logic [AW-1:0]     dot_idx_i;
    logic              dot_seen_i;
    logic              ext_len_ok;
    logic [CW-1:0]     tail_len;
    fnh_pkg::t_ext_hit ext;
    logic              ext_hit;

    always_comb begin
        room       = r_cnt < CW'(MAX_LEN);
        first_dot  = room && (i_in.char_code == fnh_pkg::CHAR_DOT) && !r_dot_seen;
        cnt_i      = room ? r_cnt + CW'(1) : r_cnt;
        dot_seen_i = r_dot_seen || first_dot;
        dot_idx_i  = first_dot ? r_cnt[AW-1:0] : r_dot_idx;
        tail_len   = cnt_i - CW'(dot_idx_i);
        ext_len_ok = dot_seen_i && (tail_len == CW'(4));
        ext        = fnh_pkg::ext_lookup({fnh_pkg::to_lower(r_c1),
                                          fnh_pkg::to_lower(r_c0),
                                          fnh_pkg::to_lower(i_in.char_code)});
        ext_hit    = ext_len_ok && ext.hit;

        o_we    = i_accept && room;
        o_waddr = r_cnt[AW-1:0];
        o_wdata = i_in.char_code;
        o_push  = i_accept && i_in.last_char;

        o_job.end_cnt  = ext_hit ? fnh_pkg::JOB_CNT_W'(cnt_i - CW'(4))
                                 : fnh_pkg::JOB_CNT_W'(cnt_i);
        o_job.code     = ext_hit ? ext.code : '0;
        o_job.no_dot   = !dot_seen_i;
        o_job.too_long = r_ovf || !room;

        n_cnt      = r_cnt;
        n_dot_idx  = r_dot_idx;
        n_dot_seen = r_dot_seen;
        n_ovf      = r_ovf;
        if (i_accept) begin
            if (i_in.last_char) begin
                n_cnt      = '0;
                n_dot_idx  = '0;
                n_dot_seen = 1'b0;
                n_ovf      = 1'b0;
            end else begin
                n_cnt      = cnt_i;
                n_dot_idx  = dot_idx_i;
                n_dot_seen = dot_seen_i;
                n_ovf      = r_ovf || !room;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_dot_idx  <= '0;
            r_dot_seen <= 1'b0;
            r_ovf      <= 1'b0;
        end else begin
            r_cnt      <= n_cnt;
            r_dot_idx  <= n_dot_idx;
            r_dot_seen <= n_dot_seen;
            r_ovf      <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_c1 <= r_c0;
            r_c0 <= i_in.char_code;
        end
    end

endmodule

### rtl/fnh_queue.sv
// ----------------------------------------------------------------------------
// fnh_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module fnh_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fnh_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_empty,
    output logic          o_full,
    output fnh_pkg::t_job o_job
);

    fnh_pkg::t_job r_q [2];
    logic          r_wp, n_wp;
    logic          r_rp, n_rp;
    logic [1:0]    r_n, n_n;
    logic          do_push, do_pop;

    always_comb begin
        o_empty = (r_n == 2'd0);
        o_full  = (r_n == 2'd2);
        o_job   = r_q[r_rp];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        n_wp    = do_push ? ~r_wp : r_wp;
        n_rp    = do_pop ? ~r_rp : r_rp;
        n_n     = r_n + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_n  <= 2'd0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_n  <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_job;
        end
    end

endmodule

### rtl/fnh_back.sv
// ----------------------------------------------------------------------------
// fnh_back
// Walks the stored name from the end, one character per cycle, and packs
// the sum, count, xor and extension code into the hash word.
// ----------------------------------------------------------------------------
module fnh_back #(
    parameter int MAX_LEN = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    input  fnh_pkg::t_job              i_job,
    output logic                       o_pop,
    output logic                       o_busy,
    output logic                       o_re,
    output logic [$clog2(MAX_LEN)-1:0] o_raddr,
    input  logic [7:0]                 i_rdata,
    output logic                       o_done,
    output fnh_pkg::t_out              o_out
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = 8 + CW;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                           r_state, n_state;
    logic [CW-1:0]                  r_idx, n_idx;
    logic                           r_rd_v;
    logic [fnh_pkg::EXT_CODE_W-1:0] r_code;
    logic                           r_zero;
    logic                           r_long;
    logic [CW-1:0]                  r_cnt;
    logic [fnh_pkg::SUM_W-1:0]      r_sum;
    logic [fnh_pkg::XOR_W-1:0]      r_xor;
    logic                           r_done;
    fnh_pkg::t_out                  r_out;

    logic [CW-1:0]                  idx_m1;
    logic [7:0]                     val;
    logic [PW-1:0]                  prod;
    logic                           finish;
    logic [31:0]                    hash;

    always_comb begin
        o_pop   = (r_state == ST_IDLE) && i_job_valid;
        o_busy  = (r_state == ST_RUN);
        idx_m1  = r_idx - CW'(1);
        o_re    = (r_state == ST_RUN) && (r_idx != '0);
        o_raddr = idx_m1[AW-1:0];
        val     = fnh_pkg::hash_value(i_rdata);
        prod    = PW'(val) * PW'(r_cnt);
        finish  = (r_state == ST_RUN) && (r_idx == '0) && !r_rd_v;
        hash    = (32'(r_cnt) << 27) | (32'(r_sum) << 15) | (32'(r_xor) << 3)
                | 32'(r_code);

        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = ST_RUN;
                    n_idx   = (i_job.no_dot || i_job.too_long) ? '0 : CW'(i_job.end_cnt);
                end
            end
            ST_RUN: begin
                if (o_re) begin
                    n_idx = idx_m1;
                end
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rd_v  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= o_re;
            r_done  <= finish;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (o_pop) begin
            r_code <= i_job.code;
            r_zero <= i_job.no_dot;
            r_long <= i_job.too_long;
            r_cnt  <= '0;
            r_sum  <= '0;
            r_xor  <= '0;
        end else if (r_rd_v && i_rdata != fnh_pkg::CHAR_BSLASH) begin
            r_sum <= r_sum + fnh_pkg::SUM_W'(val);
            r_xor <= r_xor ^ fnh_pkg::XOR_W'(prod);
            r_cnt <= r_cnt + CW'(1);
        end
        if (finish) begin
            r_out.name_hash     <= (r_zero || r_long) ? 32'd0 : hash;
            r_out.name_too_long <= r_long;
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

### rtl/file_name_hash.sv
// ----------------------------------------------------------------------------
// file_name_hash
// Hashes a file name delivered one character per word into a 32-bit value.
// ----------------------------------------------------------------------------
// The result strobe follows the walk of the stored name from the end: K
// characters are walked (N, or N - 4 on a known extension), none when
// nothing is to be walked (no dot, too long, empty stem).
// One name at a time: a new name is accepted only once the walk is done.
// Busy holds from the last character until the strobe.
// Reset (i_rst_n low, synchronous) drops any partial name and pending job.
`include "file_name_hash_defines.svh"

module file_name_hash #(
    parameter int MAX_NAME_LEN = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  fnh_pkg::t_in   i_in,
    output logic           o_done,
    output fnh_pkg::t_out  o_out
);

    localparam int AW = $clog2(MAX_NAME_LEN);

    logic          accept;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    logic          push;
    logic          pop;
    logic          q_empty;
    logic          q_full;
    logic          back_busy;
    fnh_pkg::t_job job_in;
    fnh_pkg::t_job job_out;

    assign accept = i_start && !o_busy;
    assign o_busy = !q_empty || back_busy;

    fnh_front #(
        .MAX_LEN (MAX_NAME_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_push   (push),
        .o_job    (job_in)
    );

    fnh_ram #(
        .WIDTH (8),
        .DEPTH (MAX_NAME_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    fnh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_job   (job_out)
    );

    fnh_back #(
        .MAX_LEN (MAX_NAME_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_busy      (back_busy),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_done      (o_done),
        .o_out       (o_out)
    );

    `FNH_ASSERT_NEXT(a_last_sets_busy, accept && i_in.last_char, o_busy)
    `FNH_ASSERT_NOW(a_no_write_during_walk, we, !back_busy)
    `FNH_ASSERT_NOW(a_too_long_zero, o_done && o_out.name_too_long, o_out.name_hash == 32'd0)
    `FNH_ASSERT_NOW(a_queue_not_full, push, !q_full)

endmodule
